// ===== rtl/ffha_pkg.sv =====
// Shared constants, header type and chain arithmetic for the first-fit heap allocator.
package ffha_pkg;

    // Heap geometry.
    localparam int HEAP_BYTES   = 1024;
    localparam int HEADER_BYTES = 8;

    // Field widths of the request and response channels.
    localparam int FIELD_W = 10;

    // Request operation codes carried in the func field.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Header store indexing and chain offsets (an offset may equal HEAP_BYTES).
    localparam int IDX_W  = $clog2(HEAP_BYTES);
    localparam int OFF_W  = IDX_W + 1;
    localparam int SIZE_W = IDX_W;
    localparam int CALC_W = ((OFF_W > FIELD_W) ? OFF_W : FIELD_W) + 2;

    // One block header: free mark and payload size.
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] size;
    } hdr_t;

    // Write request into the header store.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        hdr_t             data;
    } ram_wr_t;

    // Header of the single free block that spans the heap after reset.
    localparam hdr_t RESET_HDR = '{free: 1'b1, size: SIZE_W'(HEAP_BYTES - HEADER_BYTES)};

    // A header fits when at least one header's worth of bytes remains.
    function automatic logic hdr_fits(input logic [OFF_W-1:0] off);
        return off <= OFF_W'(HEAP_BYTES - HEADER_BYTES);
    endfunction

    // Offset of the following block, clamped to the heap end.
    function automatic logic [OFF_W-1:0] next_off(input logic [OFF_W-1:0] off,
                                                  input logic [SIZE_W-1:0] size);
        logic [CALC_W-1:0] sum;
        sum = CALC_W'(off) + CALC_W'(HEADER_BYTES) + CALC_W'(size);
        if (sum > CALC_W'(HEAP_BYTES))
        begin
            return OFF_W'(HEAP_BYTES);
        end
        return OFF_W'(sum);
    endfunction

endpackage

// ===== rtl/ffha_if.sv =====
// Valid/ready channel interfaces for allocator requests and responses.
interface ffha_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [ffha_pkg::FIELD_W-1:0] req_size;
    logic [ffha_pkg::FIELD_W-1:0] release_addr;

    modport source (output valid, func, req_size, release_addr, input ready);
    modport sink   (input valid, func, req_size, release_addr, output ready);
endinterface

interface ffha_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffha_pkg::FIELD_W-1:0] payload_addr;
    logic                         granted;

    modport source (output valid, payload_addr, granted, input ready);
    modport sink   (input valid, payload_addr, granted, output ready);
endinterface

// ===== rtl/ffha_hdr_ram.sv =====
// Header store: one write port, one registered read port, write-first on collision.
module ffha_hdr_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ffha_pkg::ram_wr_t          wr,
    input  logic [ffha_pkg::IDX_W-1:0] rd_addr,
    output ffha_pkg::hdr_t             rd_data
);

    ffha_pkg::hdr_t mem [ffha_pkg::HEAP_BYTES];
    ffha_pkg::hdr_t rd_data_reg;
    logic           init_pending_reg;

    // Entry 0 reads as the spanning free block until it is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_pending_reg <= 1'b1;
        end
        else if (wr.en && wr.addr == '0)
        begin
            init_pending_reg <= 1'b0;
        end
    end

    // Array write.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read with forwarding of a same-cycle write.
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.addr == rd_addr)
        begin
            rd_data_reg <= wr.data;
        end
        else if (init_pending_reg && rd_addr == '0)
        begin
            rd_data_reg <= ffha_pkg::RESET_HDR;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator: chain walker, splitter and coalescer over a header store.
//
//  channel  | dir | payload                          | accepted when
//  ---------+-----+----------------------------------+-------------------
//  req      | in  | func, req_size, release_addr     | valid & ready
//  rsp      | out | payload_addr, granted            | valid & ready
//
// Every header on the chain is read from the store one per cycle; an allocate walks
// the chain to the first fit, and a release walks to the block, then makes a coalescing
// pass from offset 0. A null release (address 0) goes straight to the result.
// Reset leaves one free block spanning the heap; entry 0 reads as that block until
// first written, so no clearing pass runs. A stalled response waits in its own register
// while the next request is taken; a further result waits until that transfer is done.
module first_fit_heap_allocator (
    input  logic              clk,
    input  logic              rst_n,
    ffha_req_if.sink          req,
    ffha_rsp_if.source        rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_WALK,
        ST_ALLOC_FIX,
        ST_REL_WALK,
        ST_COAL_A,
        ST_COAL_B,
        ST_RESULT
    } state_t;

    state_t                         state_reg, state_next;
    logic [ffha_pkg::OFF_W-1:0]     cur_reg, cur_next;
    logic [ffha_pkg::OFF_W-1:0]     nx_reg, nx_next;
    ffha_pkg::hdr_t                 a_reg, a_next;
    logic [ffha_pkg::FIELD_W-1:0]   req_reg, req_next;
    logic [ffha_pkg::FIELD_W-1:0]   addr_reg, addr_next;
    logic                           func_reg, func_next;
    logic [ffha_pkg::FIELD_W-1:0]   res_pay_reg, res_pay_next;
    logic                           res_grant_reg, res_grant_next;
    logic                           out_valid_reg, out_valid_next;
    logic [ffha_pkg::FIELD_W-1:0]   out_pay_reg, out_pay_next;
    logic                           out_grant_reg, out_grant_next;

    ffha_pkg::ram_wr_t              wr;
    logic [ffha_pkg::IDX_W-1:0]     rd_addr;
    ffha_pkg::hdr_t                 hdr;

    logic                           in_xfer;
    logic                           out_free;
    logic [ffha_pkg::OFF_W-1:0]     walk_nx;
    logic [ffha_pkg::OFF_W-1:0]     b_nx;
    logic [ffha_pkg::CALC_W-1:0]    req_w;
    logic [ffha_pkg::CALC_W-1:0]    size_w;
    logic [ffha_pkg::CALC_W-1:0]    rem_off;
    logic [ffha_pkg::CALC_W-1:0]    merged;
    logic [ffha_pkg::FIELD_W-1:0]   cur_pay;
    logic                           fits_cur;
    logic                           take;
    logic                           split;

    ffha_hdr_ram u_hdr_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (hdr)
    );

    assign req.ready        = (state_reg == ST_IDLE);
    assign in_xfer          = req.valid && req.ready;
    assign out_free         = !out_valid_reg || rsp.ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.payload_addr = out_pay_reg;
    assign rsp.granted      = out_grant_reg;

    // Chain arithmetic on the header just read.
    assign fits_cur = ffha_pkg::hdr_fits(cur_reg);
    assign walk_nx  = ffha_pkg::next_off(cur_reg, hdr.size);
    assign b_nx     = ffha_pkg::next_off(nx_reg, hdr.size);
    assign req_w    = ffha_pkg::CALC_W'(req_reg);
    assign size_w   = ffha_pkg::CALC_W'(hdr.size);
    assign rem_off  = ffha_pkg::CALC_W'(cur_reg) + ffha_pkg::CALC_W'(ffha_pkg::HEADER_BYTES)
                      + req_w;
    assign merged   = ffha_pkg::CALC_W'(a_reg.size)
                      + ffha_pkg::CALC_W'(ffha_pkg::HEADER_BYTES) + size_w;
    assign cur_pay  = ffha_pkg::FIELD_W'(ffha_pkg::CALC_W'(cur_reg)
                      + ffha_pkg::CALC_W'(ffha_pkg::HEADER_BYTES));
    assign take     = hdr.free && (size_w >= req_w);
    assign split    = (size_w > req_w + ffha_pkg::CALC_W'(ffha_pkg::HEADER_BYTES))
                      && (rem_off < ffha_pkg::CALC_W'(ffha_pkg::HEAP_BYTES));

    // Next-state and store access logic.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        nx_next        = nx_reg;
        a_next         = a_reg;
        req_next       = req_reg;
        addr_next      = addr_reg;
        func_next      = func_reg;
        res_pay_next   = res_pay_reg;
        res_grant_next = res_grant_reg;
        out_valid_next = out_valid_reg;
        out_pay_next   = out_pay_reg;
        out_grant_next = out_grant_reg;
        wr             = '0;
        rd_addr        = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    req_next       = req.req_size;
                    addr_next      = req.release_addr;
                    func_next      = req.func;
                    cur_next       = '0;
                    res_pay_next   = '0;
                    res_grant_next = 1'b0;
                    if (req.func == ffha_pkg::OP_ALLOC)
                    begin
                        state_next = ST_ALLOC_WALK;
                    end
                    else if (req.release_addr != '0)
                    begin
                        state_next = ST_REL_WALK;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end

            // First-fit search; split the block when the remainder holds a header.
            ST_ALLOC_WALK:
            begin
                if (!fits_cur)
                begin
                    state_next = ST_RESULT;
                end
                else if (take)
                begin
                    res_pay_next   = cur_pay;
                    res_grant_next = 1'b1;
                    wr.en          = 1'b1;
                    if (split)
                    begin
                        wr.addr       = ffha_pkg::IDX_W'(rem_off);
                        wr.data.free  = 1'b1;
                        wr.data.size  = ffha_pkg::SIZE_W'(size_w - req_w
                                        - ffha_pkg::CALC_W'(ffha_pkg::HEADER_BYTES));
                        state_next    = ST_ALLOC_FIX;
                    end
                    else
                    begin
                        wr.addr       = cur_reg[ffha_pkg::IDX_W-1:0];
                        wr.data.free  = 1'b0;
                        wr.data.size  = hdr.size;
                        state_next    = ST_RESULT;
                    end
                end
                else
                begin
                    cur_next = walk_nx;
                    rd_addr  = walk_nx[ffha_pkg::IDX_W-1:0];
                end
            end

            // Shrink the granted block to the requested size.
            ST_ALLOC_FIX:
            begin
                wr.en        = 1'b1;
                wr.addr      = cur_reg[ffha_pkg::IDX_W-1:0];
                wr.data.free = 1'b0;
                wr.data.size = ffha_pkg::SIZE_W'(req_reg);
                state_next   = ST_RESULT;
            end

            // Find the released block and mark it free, then coalesce from offset 0.
            ST_REL_WALK:
            begin
                if (!fits_cur)
                begin
                    cur_next   = '0;
                    state_next = ST_COAL_A;
                end
                else if (cur_pay == addr_reg)
                begin
                    wr.en        = 1'b1;
                    wr.addr      = cur_reg[ffha_pkg::IDX_W-1:0];
                    wr.data.free = 1'b1;
                    wr.data.size = hdr.size;
                    cur_next     = '0;
                    state_next   = ST_COAL_A;
                end
                else
                begin
                    cur_next = walk_nx;
                    rd_addr  = walk_nx[ffha_pkg::IDX_W-1:0];
                end
            end

            // Coalescing pass: look for a free block followed by a free block.
            ST_COAL_A:
            begin
                if (!fits_cur)
                begin
                    state_next = ST_RESULT;
                end
                else if (hdr.free && ffha_pkg::hdr_fits(walk_nx))
                begin
                    a_next     = hdr;
                    nx_next    = walk_nx;
                    rd_addr    = walk_nx[ffha_pkg::IDX_W-1:0];
                    state_next = ST_COAL_B;
                end
                else
                begin
                    cur_next = walk_nx;
                    rd_addr  = walk_nx[ffha_pkg::IDX_W-1:0];
                end
            end

            // Absorb the following block while it is free.
            ST_COAL_B:
            begin
                if (hdr.free)
                begin
                    wr.en        = 1'b1;
                    wr.addr      = cur_reg[ffha_pkg::IDX_W-1:0];
                    wr.data.free = 1'b1;
                    wr.data.size = ffha_pkg::SIZE_W'(merged);
                    a_next.size  = ffha_pkg::SIZE_W'(merged);
                    nx_next      = b_nx;
                    rd_addr      = b_nx[ffha_pkg::IDX_W-1:0];
                    if (!ffha_pkg::hdr_fits(b_nx))
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else
                begin
                    cur_next   = b_nx;
                    rd_addr    = b_nx[ffha_pkg::IDX_W-1:0];
                    state_next = ST_COAL_A;
                end
            end

            // Hand the result to the output register once it is free.
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_pay_next   = res_pay_reg;
                    out_grant_next = res_grant_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            nx_reg        <= '0;
            a_reg         <= '0;
            req_reg       <= '0;
            addr_reg      <= '0;
            func_reg      <= 1'b0;
            res_pay_reg   <= '0;
            res_grant_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pay_reg   <= '0;
            out_grant_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            nx_reg        <= nx_next;
            a_reg         <= a_next;
            req_reg       <= req_next;
            addr_reg      <= addr_next;
            func_reg      <= func_next;
            res_pay_reg   <= res_pay_next;
            res_grant_reg <= res_grant_next;
            out_valid_reg <= out_valid_next;
            out_pay_reg   <= out_pay_next;
            out_grant_reg <= out_grant_next;
        end
    end

    // A header write never lands past the last place a header fits.
    a_wr_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> ({1'b0, wr.addr} <= ffha_pkg::OFF_W'(ffha_pkg::HEAP_BYTES
                                                       - ffha_pkg::HEADER_BYTES)))
        else $error("header write beyond heap end");

    // The resize step only follows a split found by the search.
    a_fix_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC_FIX) |-> ($past(state_reg) == ST_ALLOC_WALK))
        else $error("resize step without a preceding search");

    // Merging only starts from a free block.
    a_merge_from_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COAL_B) |-> a_reg.free)
        else $error("merge attempted from a used block");

    // A release never reports a grant.
    a_release_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && func_reg) |-> !res_grant_reg)
        else $error("release produced a grant");

    // A finished result reaches the output register in the next cycle.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not moved to the output register");

endmodule
